[sv/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg
// shared types and constants for the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_DEL_FRONT = 3'd1,
        ACT_INS_REAR  = 3'd2,
        ACT_DEL_REAR  = 3'd3,
        ACT_INS_POS   = 3'd4,
        ACT_DEL_POS   = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // command from the control logic to the shift engine
    typedef struct packed {
        logic                     start;
        logic                     del;
        logic [IDX_W-1:0]         idx;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] item;
    } eng_cmd_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] removed;
    } eng_rsp_t;

endpackage

[sv/pls_req_if.sv]
// ----------------------------------------------------------------------------
// pls_req_if
// request channel: valid/ready handshake with action, item and position
// ----------------------------------------------------------------------------
interface pls_req_if;

    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic signed [31:0] item_value;
    logic [6:0]  position;

    modport source (output valid, output action, output item_value, output position,
                    input ready);
    modport sink   (input valid, input action, input item_value, input position,
                    output ready);

endinterface

[sv/pls_rsp_if.sv]
// ----------------------------------------------------------------------------
// pls_rsp_if
// result channel: valid/ready handshake with status, removed item and length
// ----------------------------------------------------------------------------
interface pls_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] removed_value;
    logic [6:0]  list_length;

    modport source (output valid, output status, output removed_value,
                    output list_length, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input list_length, output ready);

endinterface

[sv/positional_list_store_core.sv]
// ----------------------------------------------------------------------------
// positional_list_store_core
// ordered list of signed 32-bit items with insert and delete by position
// ----------------------------------------------------------------------------
// usage:
//   req carries one request item: action, item_value, position. rsp returns
//   exactly one result item per request: status, removed_value, list_length.
//   both channels move an item when valid and ready are high at a clock edge.
// sequencing:
//   a request that is rejected (empty, full, bad position) or an unused
//   action code gives its result in the cycle after acceptance. an insert
//   or delete moves the entries behind the gap through the entry memory,
//   one entry per cycle, and moves none for an insert at the rear. one
//   request is worked on at a time.
// reset:
//   rst_n clears the item count, so the list is empty; the entry memory is
//   not cleared and needs no sweep.
// stalls:
//   the result sits in an output register until taken; a new request is
//   accepted in the same cycle the previous result leaves, never earlier.
// ----------------------------------------------------------------------------
module positional_list_store_core (
    input  logic     clk,
    input  logic     rst_n,
    pls_req_if.sink  req,
    pls_rsp_if.source rsp
);
    import pls_pkg::*;

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        T_IDLE = 2'b01,
        T_RUN  = 2'b10
    } top_state_t;

    top_state_t               state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     del_op_reg;
    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic signed [DATA_W-1:0] out_removed_reg;
    logic [LEN_W-1:0]         out_length_reg;

    logic             out_free;
    logic             accept;
    status_t          dec_status;
    logic             dec_start;
    logic             dec_del;
    logic [IDX_W-1:0] dec_idx;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count_next;
    eng_cmd_t         eng_cmd;
    eng_rsp_t         eng_rsp;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == T_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign pos_w = CMP_W'(req.position);
    assign cnt_w = CMP_W'(count_reg);
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb
    begin
        dec_status = ST_DONE;
        dec_start  = 1'b0;
        dec_del    = 1'b0;
        dec_idx    = '0;
        unique case (req.action)
            ACT_INS_FRONT:
            begin
                if (full) dec_status = ST_FULL;
                else      dec_start  = 1'b1;
            end
            ACT_INS_REAR:
            begin
                dec_idx = IDX_W'(count_reg);
                if (full) dec_status = ST_FULL;
                else      dec_start  = 1'b1;
            end
            ACT_INS_POS:
            begin
                dec_idx = IDX_W'(pos_w - CMP_W'(1));
                if (full)
                    dec_status = ST_FULL;
                else if (pos_w >= CMP_W'(1) && pos_w <= cnt_w + CMP_W'(1))
                    dec_start = 1'b1;
                else
                    dec_status = ST_BADPOS;
            end
            ACT_DEL_FRONT:
            begin
                dec_del = 1'b1;
                if (empty) dec_status = ST_EMPTY;
                else       dec_start  = 1'b1;
            end
            ACT_DEL_REAR:
            begin
                dec_del = 1'b1;
                dec_idx = IDX_W'(count_reg - CNT_W'(1));
                if (empty) dec_status = ST_EMPTY;
                else       dec_start  = 1'b1;
            end
            ACT_DEL_POS:
            begin
                dec_del = 1'b1;
                dec_idx = IDX_W'(pos_w - CMP_W'(1));
                if (empty)
                    dec_status = ST_EMPTY;
                else if (pos_w >= CMP_W'(1) && pos_w <= cnt_w)
                    dec_start = 1'b1;
                else
                    dec_status = ST_BADPOS;
            end
            // unused codes leave the list alone and report done
            default: ;
        endcase
    end

    always_comb
    begin
        eng_cmd.start = accept && dec_start;
        eng_cmd.del   = dec_del;
        eng_cmd.idx   = dec_idx;
        eng_cmd.count = count_reg;
        eng_cmd.item  = req.item_value;
    end

    pls_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (eng_cmd),
        .rsp   (eng_rsp)
    );

    assign count_next = del_op_reg ? count_reg - CNT_W'(1) : count_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (accept && dec_start)
            begin
                state_reg <= T_RUN;
                if (rsp.ready)
                    out_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == T_RUN && eng_rsp.done)
            begin
                state_reg     <= T_IDLE;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && dec_start)
        begin
            del_op_reg <= dec_del;
        end
        else if (accept)
        begin
            out_status_reg  <= dec_status;
            out_removed_reg <= '0;
            out_length_reg  <= LEN_W'(count_reg);
        end
        else if (state_reg == T_RUN && eng_rsp.done)
        begin
            out_status_reg  <= ST_DONE;
            out_removed_reg <= del_op_reg ? eng_rsp.removed : '0;
            out_length_reg  <= LEN_W'(count_next);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.list_length   = out_length_reg;

endmodule

[sv/pls_engine.sv]
// ----------------------------------------------------------------------------
// pls_engine
// entry memory with a sequencer that moves entries one per cycle to open or
// close a gap, then writes the new item or hands back the removed one
// ----------------------------------------------------------------------------
module pls_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  pls_pkg::eng_cmd_t cmd,
    output pls_pkg::eng_rsp_t rsp
);
    import pls_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE = 2'b01,
        E_RUN  = 2'b10
    } eng_state_t;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    eng_state_t               state_reg, state_next;
    logic                     del_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         rd_ptr_reg;
    logic [CNT_W-1:0]         left_reg;
    logic                     pend_reg;
    logic                     first_reg;
    logic [IDX_W-1:0]         last_reg;
    logic signed [DATA_W-1:0] item_reg;
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] removed_reg;

    logic                     rd_en;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     finish;

    always_comb
    begin
        rd_en   = (state_reg == E_RUN) && (left_reg != '0);
        finish  = (state_reg == E_RUN) && (left_reg == '0) && !pend_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = item_reg;
        if (state_reg == E_RUN)
        begin
            if (pend_reg)
            begin
                // moved entry lands one place away from where it was read
                if (!del_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = last_reg + IDX_W'(1);
                    wr_data = rdata_reg;
                end
                else if (!first_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = last_reg - IDX_W'(1);
                    wr_data = rdata_reg;
                end
            end
            else if (finish && !del_reg)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:  if (cmd.start) state_next = E_RUN;
            E_RUN:   if (finish) state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == E_IDLE && cmd.start)
            begin
                left_reg  <= cmd.count - CNT_W'(cmd.idx);
                pend_reg  <= 1'b0;
                first_reg <= 1'b1;
            end
            else if (state_reg == E_RUN)
            begin
                pend_reg <= rd_en;
                if (pend_reg)
                    first_reg <= 1'b0;
                if (rd_en)
                    left_reg <= left_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == E_IDLE && cmd.start)
        begin
            del_reg  <= cmd.del;
            idx_reg  <= cmd.idx;
            item_reg <= cmd.item;
            // insert walks down from the rear, delete walks up from the gap
            rd_ptr_reg <= cmd.del ? cmd.idx : IDX_W'(cmd.count - CNT_W'(1));
        end
        else if (rd_en)
        begin
            last_reg   <= rd_ptr_reg;
            rd_ptr_reg <= del_reg ? rd_ptr_reg + IDX_W'(1) : rd_ptr_reg - IDX_W'(1);
        end
        if (state_reg == E_RUN && pend_reg && del_reg && first_reg)
            removed_reg <= rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_ptr_reg];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    assign rsp.done    = finish;
    assign rsp.removed = removed_reg;

endmodule
